// ----- hdl/dnd_pkg.sv -----
`timescale 1ns / 1ps
// dnd_pkg: types, constants and microcode store for the day number to date unit.
// No dependencies.
package dnd_pkg;

  localparam int unsigned UPC_BITS = 2;
  typedef logic [UPC_BITS-1:0] upc_t;

  localparam logic [10:0] BASE_YEAR    = 11'd1970;
  localparam logic [1:0]  BASE_MOD4    = 2'd2;
  localparam logic [6:0]  BASE_MOD100  = 7'd70;
  localparam logic [8:0]  BASE_MOD400  = 9'd370;
  localparam logic [6:0]  CENTURY_LAST = 7'd99;
  localparam logic [8:0]  QUAD_LAST    = 9'd399;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam logic [8:0]  DAYS_COMMON  = 9'd365;
  localparam logic [3:0]  MONTH_DEC    = 4'd11;
  localparam logic [3:0]  MONTH_FEB    = 4'd1;

  localparam upc_t STEP_IDLE  = 2'd0;
  localparam upc_t STEP_YEAR  = 2'd1;
  localparam upc_t STEP_MONTH = 2'd2;
  localparam upc_t STEP_EMIT  = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    COND_START,
    COND_YEAR_FITS,
    COND_MONTH_FITS,
    COND_ALWAYS
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  tgt_true;
    upc_t  tgt_false;
  } uword_t;

  function automatic uword_t ucode(upc_t addr);
    uword_t w;
    case (addr)
      STEP_IDLE:  w = '{OP_LOAD,  COND_START,      STEP_YEAR,  STEP_IDLE};
      STEP_YEAR:  w = '{OP_YEAR,  COND_YEAR_FITS,  STEP_YEAR,  STEP_MONTH};
      STEP_MONTH: w = '{OP_MONTH, COND_MONTH_FITS, STEP_MONTH, STEP_EMIT};
      STEP_EMIT:  w = '{OP_EMIT,  COND_ALWAYS,     STEP_IDLE,  STEP_IDLE};
      default:    w = '{OP_EMIT,  COND_ALWAYS,     STEP_IDLE,  STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic is_leap);
    logic [4:0] len;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      MONTH_FEB:                                 len = is_leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/day_number_to_date_unit.sv -----
`timescale 1ns / 1ps
// day_number_to_date_unit: days since 1970-01-01 to Gregorian year/month/day.
// Depends on dnd_pkg (microcode store, month table, constants).
//
// A conversion starts on start while busy is low and ends with a one-cycle
// done_o beat carrying year_o, month_o and day_of_month_o; the receiver
// cannot stall it. A four-step microprogram drives one subtractor: a load
// step, a year-length loop that takes off one elapsed year per pass, a month
// loop that takes off one whole month per pass (at most 11), and an emit
// step. busy stays high throughout, so items are converted one at a time.
module day_number_to_date_unit #(
  parameter int unsigned DAY_NUMBER_BITS = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [DAY_NUMBER_BITS-1:0] day_number_i,
  output logic                       done_o,
  output logic [12:0]                year_o,
  output logic [3:0]                 month_o,
  output logic [4:0]                 day_of_month_o
);
  import dnd_pkg::*;

  localparam int unsigned YEAR_BITS = (DAY_NUMBER_BITS > 20) ? DAY_NUMBER_BITS - 7 : 13;

  upc_t                       upc_q, upc_d;
  uword_t                     uw;
  logic [DAY_NUMBER_BITS-1:0] rest_q, rest_d;
  logic [YEAR_BITS-1:0]       year_q, year_d;
  logic [1:0]                 mod4_q, mod4_d;
  logic [6:0]                 mod100_q, mod100_d;
  logic [8:0]                 mod400_q, mod400_d;
  logic [3:0]                 month_q, month_d;

  logic                       is_leap;
  logic [DAY_NUMBER_BITS-1:0] ylen, mlen;
  logic                       year_fits, month_fits, cond_ok;

  assign uw      = ucode(upc_q);
  assign is_leap = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
  assign ylen    = {{(DAY_NUMBER_BITS-9){1'b0}}, (is_leap ? DAYS_LEAP : DAYS_COMMON)};
  assign mlen    = {{(DAY_NUMBER_BITS-5){1'b0}}, month_len(month_q, is_leap)};
  assign year_fits  = rest_q >= ylen;
  assign month_fits = (month_q < MONTH_DEC) && (rest_q >= mlen);

  // sequencer
  always_comb begin
    case (uw.cond)
      COND_START:      cond_ok = start;
      COND_YEAR_FITS:  cond_ok = year_fits;
      COND_MONTH_FITS: cond_ok = month_fits;
      COND_ALWAYS:     cond_ok = 1'b1;
      default:         cond_ok = 1'b1;
    endcase
    upc_d = cond_ok ? uw.tgt_true : uw.tgt_false;
  end

  // datapath
  always_comb begin
    rest_d   = rest_q;
    year_d   = year_q;
    mod4_d   = mod4_q;
    mod100_d = mod100_q;
    mod400_d = mod400_q;
    month_d  = month_q;
    case (uw.op)
      OP_LOAD: begin
        rest_d   = day_number_i;
        year_d   = YEAR_BITS'(BASE_YEAR);
        mod4_d   = BASE_MOD4;
        mod100_d = BASE_MOD100;
        mod400_d = BASE_MOD400;
        month_d  = 4'd0;
      end
      OP_YEAR: begin
        if (year_fits) begin
          rest_d   = rest_q - ylen;
          year_d   = year_q + YEAR_BITS'(1);
          mod4_d   = mod4_q + 2'd1;
          mod100_d = (mod100_q == CENTURY_LAST) ? 7'd0 : mod100_q + 7'd1;
          mod400_d = (mod400_q == QUAD_LAST) ? 9'd0 : mod400_q + 9'd1;
        end
      end
      OP_MONTH: begin
        if (month_fits) begin
          rest_d  = rest_q - mlen;
          month_d = month_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    year_q   <= year_d;
    mod4_q   <= mod4_d;
    mod100_q <= mod100_d;
    mod400_q <= mod400_d;
    month_q  <= month_d;
  end

  // outputs
  always_comb begin
    busy           = (upc_q != STEP_IDLE);
    done_o         = (uw.op == OP_EMIT);
    year_o         = year_q[12:0];
    month_o        = month_q + 4'd1;
    day_of_month_o = rest_q[4:0] + 5'd1;
  end

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("not idle after result beat");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_o >= 4'd1) && (month_o <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rest_q < {{(DAY_NUMBER_BITS-5){1'b0}}, 5'd31}))
    else $error("day of month out of range");

endmodule

// ----- bench/day_number_to_date_checker.sv -----
`timescale 1ns / 1ps
// day_number_to_date_checker: watches the command and result channels of
// day_number_to_date_unit, predicts each date and compares it field by field.
// Standalone module; no package dependencies.
module day_number_to_date_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [19:0] day_number_i,
  input  logic        done_i,
  input  logic [12:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_of_month_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [12:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
  } cal_date_t;

  localparam int unsigned EPOCH_YEAR  = 1970;
  localparam int unsigned DAYS_PER_400 = 146097;

  cal_date_t expected_dates[$];
  int        fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = expected_dates.size();

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic cal_date_t date_of_day_number(logic [19:0] dn);
    int unsigned rest;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int unsigned mlen[12];
    cal_date_t   d;
    mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    rest = dn;
    y    = EPOCH_YEAR + 400 * (rest / DAYS_PER_400);
    rest = rest % DAYS_PER_400;
    while (rest >= (is_leap_year(y) ? 366 : 365)) begin
      rest -= is_leap_year(y) ? 366 : 365;
      y++;
    end
    m = 0;
    while (m < 11) begin
      len = (m == 1 && is_leap_year(y)) ? 29 : mlen[m];
      if (rest < len) break;
      rest -= len;
      m++;
    end
    d.year  = y[12:0];
    d.month = 4'(m + 1);
    d.dom   = 5'(rest + 1);
    return d;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin
    cal_date_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_dates.size() == 0) begin
          report("unexpected result beat, year", year_i, 0);
        end else begin
          want = expected_dates.pop_front();
          if (year_i !== want.year) report("year", year_i, want.year);
          if (month_i !== want.month) report("month", month_i, want.month);
          if (day_of_month_i !== want.dom) report("day_of_month", day_of_month_i, want.dom);
        end
      end
      if (start_i && !busy_i) expected_dates.push_back(date_of_day_number(day_number_i));
    end
  end

endmodule

// ----- bench/tb_day_number_to_date_unit.sv -----
`timescale 1ns / 1ps
// tb_day_number_to_date_unit: drives directed and random day numbers into
// day_number_to_date_unit and gives the verdict; day_number_to_date_checker does the checking.
module tb_day_number_to_date_unit;

  localparam int unsigned DN_BITS      = 20;
  localparam int unsigned N_RANDOM     = 200;
  localparam int unsigned QUIET_TAIL   = 30;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned DAYS_PER_400 = 146097;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [DN_BITS-1:0] day_number_i = '0;
  logic               done_o;
  logic [12:0]        year_o;
  logic [3:0]         month_o;
  logic [4:0]         day_of_month_o;
  int                 fail_count;
  int                 pending;
  int unsigned        stall_cycles = 0;

  day_number_to_date_unit #(.DAY_NUMBER_BITS(DN_BITS)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .day_number_i(day_number_i),
    .done_o(done_o),
    .year_o(year_o),
    .month_o(month_o),
    .day_of_month_o(day_of_month_o)
  );

  day_number_to_date_checker checker_i (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .busy_i(busy),
    .day_number_i(day_number_i),
    .done_i(done_o),
    .year_i(year_o),
    .month_i(month_o),
    .day_of_month_i(day_of_month_o),
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("day_number_to_date_unit regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // start stays high across back-to-back beats
  task automatic send_day(logic [DN_BITS-1:0] dn);
    @(negedge clk_i);
    start        <= 1'b1;
    day_number_i <= dn;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
  endtask

  task automatic hold_off(int unsigned n);
    @(negedge clk_i);
    start        <= 1'b0;
    day_number_i <= DN_BITS'($urandom);
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic logic [DN_BITS-1:0] pick_day();
    int signed k;
    case ($urandom_range(0, 7))
      0: return DN_BITS'($urandom);
      1: begin
        k = $urandom_range(1, 7) * DAYS_PER_400 + $urandom_range(0, 6) - 3;
        return DN_BITS'(k);
      end
      2: return DN_BITS'($urandom_range(0, 1500));
      default: return DN_BITS'($urandom_range(0, 40000));
    endcase
  endfunction

  initial begin
    logic [DN_BITS-1:0] directed[$];
    directed = '{
      20'd0, 20'd30, 20'd31, 20'd58, 20'd59, 20'd364, 20'd365,
      20'd789, 20'd790, 20'd1095, 20'd1096,
      20'd10957, 20'd11016, 20'd11017,
      20'd47540, 20'd47541,
      20'd146096, 20'd146097, 20'd292193, 20'd292194,
      20'd1048574, 20'd1048575
    };
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (directed[i]) send_day(directed[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        hold_off(1);
        while (pending != 0) @(negedge clk_i);
      end
      if (i < N_RANDOM - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
        hold_off($urandom_range(1, 15));
      end
      send_day(pick_day());
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("day_number_to_date_unit regression: pass");
    end else begin
      $display("day_number_to_date_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- day_number_to_date_unit.f -----
hdl/dnd_pkg.sv
hdl/day_number_to_date_unit.sv
bench/day_number_to_date_checker.sv
bench/tb_day_number_to_date_unit.sv
